[rtl/expanding_drop_pixel_renderer_core_macros.svh]
// Assertion macros shared by the renderer modules.
`ifndef EXPANDING_DROP_PIXEL_RENDERER_CORE_MACROS_SVH
`define EXPANDING_DROP_PIXEL_RENDERER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define EDPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define EDPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EDPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define EDPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/edpr_pkg.sv]
`default_nettype none

package edpr_pkg;

  localparam int unsigned GRID_WIDTH  = 12;
  localparam int unsigned GRID_HEIGHT = 9;

  localparam int unsigned StepsPerPixel = 50;
  localparam int unsigned FadeAfter     = 150;
  localparam int unsigned DieAt         = 300;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_START_RED   = 3'd2,
    CFG_START_GREEN = 3'd3,
    CFG_START_BLUE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0] radius;
    logic [3:0] whole;
    logic [5:0] frac;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       active;
  } drop_t;

  // Coefficient k is ceil(k * 2^16 / 50), so (c * coeff) >> 16 is floor(c * k / 50).
  localparam logic [15:0] FracCoeff [StepsPerPixel] = '{
    16'd0,     16'd1311,  16'd2622,  16'd3933,  16'd5243,
    16'd6554,  16'd7865,  16'd9176,  16'd10486, 16'd11797,
    16'd13108, 16'd14418, 16'd15729, 16'd17040, 16'd18351,
    16'd19661, 16'd20972, 16'd22283, 16'd23593, 16'd24904,
    16'd26215, 16'd27526, 16'd28836, 16'd30147, 16'd31458,
    16'd32768, 16'd34079, 16'd35390, 16'd36701, 16'd38011,
    16'd39322, 16'd40633, 16'd41944, 16'd43254, 16'd44565,
    16'd45876, 16'd47186, 16'd48497, 16'd49808, 16'd51119,
    16'd52429, 16'd53740, 16'd55051, 16'd56361, 16'd57672,
    16'd58983, 16'd60294, 16'd61604, 16'd62915, 16'd64226
  };

  // Nine tenths, rounded down, by a reciprocal multiply that is exact for eight bits.
  function automatic logic [7:0] fade(input logic [7:0] c);
    logic [23:0] prod;
    prod = 24'(c) * 24'd58986;
    return prod[23:16];
  endfunction

endpackage

`default_nettype wire

[rtl/edpr_shade.sv]
`default_nettype none

module edpr_shade
  import edpr_pkg::*;
(
  input  logic [7:0] colour_i,
  input  logic [5:0] frac_i,
  input  logic       near_i,
  input  logic       inside_i,
  output logic [7:0] shade_o
);

  logic [23:0] prod;
  logic [7:0]  edge_part;
  logic        inexact;

  assign prod      = 24'(colour_i) * 24'(FracCoeff[frac_i]);
  assign edge_part = prod[23:16];
  assign inexact   = |prod[15:8];

  // Inside the drop the two parts add up to the colour, less one when the edge part was rounded.
  always_comb begin
    if (inside_i) begin
      shade_o = colour_i - 8'(inexact);
    end else if (near_i) begin
      shade_o = edge_part;
    end else begin
      shade_o = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/edpr_state.sv]
`default_nettype none

module edpr_state
  import edpr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] op_i,
  input  logic [7:0] start_red_i,
  input  logic [7:0] start_green_i,
  input  logic [7:0] start_blue_i,
  output drop_t      drop_o,
  output logic       alive_next_o
);

`include "expanding_drop_pixel_renderer_core_macros.svh"

  drop_t      drop_q, drop_d;
  logic [8:0] radius_inc;

  assign radius_inc = drop_q.radius + 9'd1;

  always_comb begin
    drop_d = drop_q;
    case (op_i)
      OP_START: begin
        drop_d.radius = '0;
        drop_d.whole  = '0;
        drop_d.frac   = '0;
        drop_d.red    = start_red_i;
        drop_d.green  = start_green_i;
        drop_d.blue   = start_blue_i;
        drop_d.active = 1'b1;
      end
      OP_ADVANCE: begin
        if (drop_q.active) begin
          drop_d.radius = radius_inc;
          if (drop_q.frac == 6'(StepsPerPixel - 1)) begin
            drop_d.frac  = '0;
            drop_d.whole = drop_q.whole + 4'd1;
          end else begin
            drop_d.frac = drop_q.frac + 6'd1;
          end
          if (radius_inc > 9'(FadeAfter)) begin
            drop_d.red   = fade(drop_q.red);
            drop_d.green = fade(drop_q.green);
            drop_d.blue  = fade(drop_q.blue);
          end
          if (radius_inc >= 9'(DieAt)) begin
            drop_d.active = 1'b0;
          end
        end
      end
      default: begin
        drop_d = drop_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= '{radius: '0, whole: '0, frac: '0, red: 8'hff, green: 8'hff,
                  blue: 8'hff, active: 1'b1};
    end else if (step_i) begin
      drop_q <= drop_d;
    end
  end

  assign drop_o       = drop_q;
  assign alive_next_o = drop_d.active;

  `EDPR_ASSERT_NOW(a_radius_split, clk_i, rst_ni, 1'b1,
    (10'(drop_q.whole) * 10'd50 + 10'(drop_q.frac)) == 10'(drop_q.radius),
    "radius disagrees with its whole and fractional parts")
  `EDPR_ASSERT_NOW(a_dead_at_limit, clk_i, rst_ni, !drop_q.active,
    drop_q.radius == 9'(DieAt), "drop died away from the final radius")
  `EDPR_ASSERT_NEXT(a_start_revives, clk_i, rst_ni, step_i && (op_i == OP_START),
    drop_q.active && (drop_q.radius == '0), "start did not revive the drop")

endmodule

`default_nettype wire

[rtl/expanding_drop_pixel_renderer_core.sv]
`default_nettype none

// Renders one square drop that grows from a centre point and fades as it grows. Each input
// word starts the drop, advances it by one frame, reads one pixel's colour or, for the unused
// code, does nothing, and gives exactly one result word. One word is taken every cycle unless
// the result side stalls: a word passes an input register and a result register, and its
// result is presented once the word moves on into the result register. Input ready drops
// only while both registers hold words and the result side is not taking one. The drop state
// is updated as a word leaves the input register, so a read sees every earlier advance. The
// colour shading is one 8 by 16 bit multiply per channel by a coefficient from a small
// constant table. Configuration writes are taken at any time but belong in idle periods; cfg_ready_o is always high.
module expanding_drop_pixel_renderer_core
  import edpr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] pixel_x_i,
  input  logic [3:0] pixel_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       alive_o
);

`include "expanding_drop_pixel_renderer_core_macros.svh"

  logic [3:0] center_x_q, center_y_q;
  logic [7:0] start_red_q, start_green_q, start_blue_q;

  logic       a_valid_q;
  logic [1:0] a_op_q;
  logic [3:0] a_px_q, a_py_q;

  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       alive_q;

  logic       in_take, out_free, move;
  drop_t      drop;
  logic       alive_next;
  logic [3:0] dx, dy, reach;
  logic       on_grid, lit, near, covered;
  logic [7:0] shade_r, shade_g, shade_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= 4'd3;
      center_y_q    <= 4'd4;
      start_red_q   <= 8'hff;
      start_green_q <= 8'hff;
      start_blue_q  <= 8'hff;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTER_X:    center_x_q    <= cfg_data_i[3:0];
        CFG_CENTER_Y:    center_y_q    <= cfg_data_i[3:0];
        CFG_START_RED:   start_red_q   <= cfg_data_i;
        CFG_START_GREEN: start_green_q <= cfg_data_i;
        CFG_START_BLUE:  start_blue_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign move       = a_valid_q && out_free;
  assign in_ready_o = !a_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_take) begin
      a_valid_q <= 1'b1;
    end else if (move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_op_q <= operation_i;
      a_px_q <= pixel_x_i;
      a_py_q <= pixel_y_i;
    end
  end

  edpr_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (move),
    .op_i          (a_op_q),
    .start_red_i   (start_red_q),
    .start_green_i (start_green_q),
    .start_blue_i  (start_blue_q),
    .drop_o        (drop),
    .alive_next_o  (alive_next)
  );

  assign dx      = (a_px_q > center_x_q) ? a_px_q - center_x_q : center_x_q - a_px_q;
  assign dy      = (a_py_q > center_y_q) ? a_py_q - center_y_q : center_y_q - a_py_q;
  assign reach   = (dx > dy) ? dx : dy;
  assign on_grid = (9'(a_px_q) < 9'(GRID_WIDTH)) && (9'(a_py_q) < 9'(GRID_HEIGHT));
  assign lit     = (a_op_q == OP_READ) && drop.active && on_grid;
  assign near    = lit && (5'(reach) <= 5'(drop.whole) + 5'd1);
  assign covered = lit && (reach <= drop.whole);

  edpr_shade u_shade_r (
    .colour_i (drop.red),
    .frac_i   (drop.frac),
    .near_i   (near),
    .inside_i (covered),
    .shade_o  (shade_r)
  );

  edpr_shade u_shade_g (
    .colour_i (drop.green),
    .frac_i   (drop.frac),
    .near_i   (near),
    .inside_i (covered),
    .shade_o  (shade_g)
  );

  edpr_shade u_shade_b (
    .colour_i (drop.blue),
    .frac_i   (drop.frac),
    .near_i   (near),
    .inside_i (covered),
    .shade_o  (shade_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      red_q   <= shade_r;
      green_q <= shade_g;
      blue_q  <= shade_b;
      alive_q <= alive_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alive_o     = alive_q;

  `EDPR_ASSERT_NEXT(a_input_drains, clk_i, rst_ni, a_valid_q && !out_valid_q,
    out_valid_q, "held word did not reach the result register")
  `EDPR_ASSERT_NOW(a_dark_unless_read, clk_i, rst_ni, a_valid_q && (a_op_q != OP_READ),
    (shade_r == '0) && (shade_g == '0) && (shade_b == '0),
    "colour produced for a word that is not a read")
  `EDPR_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !a_valid_q,
    in_ready_o, "input not ready while the input register is empty")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

package drop_check_pkg;
  import edpr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       alive;
  } pixel_t;

  class drop_pixel_board;
    logic [3:0]  center_x;
    logic [3:0]  center_y;
    logic [7:0]  start_red;
    logic [7:0]  start_green;
    logic [7:0]  start_blue;
    logic [8:0]  radius;
    logic [7:0]  drop_red;
    logic [7:0]  drop_green;
    logic [7:0]  drop_blue;
    logic        drop_active;
    pixel_t      pixels_due[$];
    int unsigned mismatches;

    function new();
      center_x    = 4'd3;
      center_y    = 4'd4;
      start_red   = 8'd255;
      start_green = 8'd255;
      start_blue  = 8'd255;
      radius      = '0;
      drop_red    = 8'd255;
      drop_green  = 8'd255;
      drop_blue   = 8'd255;
      drop_active = 1'b1;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] data);
      case (idx)
        CFG_CENTER_X:    center_x = data[3:0];
        CFG_CENTER_Y:    center_y = data[3:0];
        CFG_START_RED:   start_red = data;
        CFG_START_GREEN: start_green = data;
        CFG_START_BLUE:  start_blue = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] nine_tenths(logic [7:0] c);
      int unsigned scaled;
      scaled = (32'(c) * 9) / 10;
      return scaled[7:0];
    endfunction

    function logic [7:0] shade(logic [7:0] c, int unsigned reach, int unsigned whole,
                               int unsigned frac);
      int unsigned sum;
      sum = 0;
      if (reach <= whole + 1) begin
        sum += (32'(c) * frac) / StepsPerPixel;
      end
      if (reach <= whole) begin
        sum += (32'(c) * (StepsPerPixel - frac)) / StepsPerPixel;
      end
      return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function void note_word(logic [1:0] op, logic [3:0] px, logic [3:0] py);
      pixel_t      due;
      int unsigned dx;
      int unsigned dy;
      int unsigned reach;
      int unsigned whole;
      int unsigned frac;
      due = '0;
      case (op)
        OP_START: begin
          radius      = '0;
          drop_red    = start_red;
          drop_green  = start_green;
          drop_blue   = start_blue;
          drop_active = 1'b1;
        end
        OP_ADVANCE: begin
          if (drop_active) begin
            radius = radius + 9'd1;
            if (radius > FadeAfter) begin
              drop_red   = nine_tenths(drop_red);
              drop_green = nine_tenths(drop_green);
              drop_blue  = nine_tenths(drop_blue);
            end
            if (radius >= DieAt) begin
              drop_active = 1'b0;
            end
          end
        end
        OP_READ: begin
          if (drop_active && px < GRID_WIDTH && py < GRID_HEIGHT) begin
            dx = (px > center_x) ? px - center_x : center_x - px;
            dy = (py > center_y) ? py - center_y : center_y - py;
            reach = (dx > dy) ? dx : dy;
            whole = radius / StepsPerPixel;
            frac  = radius % StepsPerPixel;
            due.red   = shade(drop_red, reach, whole, frac);
            due.green = shade(drop_green, reach, whole, frac);
            due.blue  = shade(drop_blue, reach, whole, frac);
          end
        end
        default: ;
      endcase
      due.alive = drop_active;
      pixels_due = {pixels_due, due};
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t due;
      if (pixels_due.size() == 0) begin
        $error("result word arrived with no expectation pending");
        mismatches++;
        return;
      end
      due = pixels_due.pop_front();
      compare_field("red", due.red, got.red);
      compare_field("green", due.green, got.green);
      compare_field("blue", due.blue, got.blue);
      compare_field("alive", due.alive, got.alive);
    endfunction
  endclass

endpackage

module testbench;
  import edpr_pkg::*;
  import drop_check_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int          PhaseWords = 428;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] operation_i = '0;
  logic [3:0] pixel_x_i   = '0;
  logic [3:0] pixel_y_i   = '0;
  logic       out_ready_i = 1'b0;
  wire        cfg_ready_o;
  wire        in_ready_o;
  wire        out_valid_o;
  wire  [7:0] red_o;
  wire  [7:0] green_o;
  wire  [7:0] blue_o;
  wire        alive_o;

  drop_pixel_board board;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  logic        hold_request   = 1'b0;
  int unsigned stalled_cycles = 0;

  expanding_drop_pixel_renderer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .alive_o    (alive_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        board.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        board.note_word(operation_i, pixel_x_i, pixel_y_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_pixel(pixel_t'{red_o, green_o, blue_o, alive_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // The long hold lets the result side back up until the input side stalls.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 80;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [3:0] px, input logic [3:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pixel_x_i   <= px;
    pixel_y_i   <= py;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [3:0] cx, input logic [3:0] cy, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    write_reg(CFG_CENTER_X, {4'd0, cx});
    write_reg(CFG_CENTER_Y, {4'd0, cy});
    write_reg(CFG_START_RED, r);
    write_reg(CFG_START_GREEN, g);
    write_reg(CFG_START_BLUE, b);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pixels_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  // Mostly whole drop lifetimes: a start, bursts of advances with reads in between,
  // and a restart shortly after the drop has died.
  task automatic run_phase(input int words, input int idle_in, input int stall_out);
    int         sent;
    int         burst;
    int         dead_run;
    int         pick;
    logic [3:0] px;
    logic [3:0] py;
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    send_word(OP_START, 4'($urandom_range(15)), 4'($urandom_range(15)));
    sent     = 1;
    dead_run = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (!board.drop_active) begin
        dead_run++;
      end
      if (dead_run > 12 || $urandom_range(499) == 0) begin
        send_word(OP_START, 4'($urandom_range(15)), 4'($urandom_range(15)));
        dead_run = 0;
        sent++;
      end else if (pick < 55) begin
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          send_word(OP_ADVANCE, 4'($urandom_range(15)), 4'($urandom_range(15)));
        end
        sent += burst;
      end else if (pick < 96) begin
        if ($urandom_range(9) == 0) begin
          px = 4'($urandom_range(15));
          py = 4'($urandom_range(15));
        end else begin
          px = 4'($urandom_range(GRID_WIDTH - 1));
          py = 4'($urandom_range(GRID_HEIGHT - 1));
        end
        send_word(OP_READ, px, py);
        sent++;
      end else begin
        send_word(OP_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_READ, 4'd3, 4'd4);
    send_word(OP_READ, 4'd4, 4'd4);
    send_word(OP_READ, 4'd0, 4'd0);
    send_word(OP_READ, 4'd11, 4'd8);
    send_word(OP_READ, 4'd12, 4'd4);
    send_word(OP_READ, 4'd3, 4'd9);
    send_word(OP_READ, 4'd15, 4'd15);
    send_word(OP_UNUSED, 4'd15, 4'd15);
    send_word(OP_ADVANCE, 4'd0, 4'd0);
    send_word(OP_READ, 4'd4, 4'd5);
    send_word(OP_READ, 4'd3, 4'd4);
    send_word(OP_READ, 4'd2, 4'd3);
    send_word(OP_START, 4'd15, 4'd15);
    send_word(OP_READ, 4'd3, 4'd4);
    send_word(OP_ADVANCE, 4'd15, 4'd0);
    send_word(OP_ADVANCE, 4'd0, 4'd15);
    send_word(OP_READ, 4'd5, 4'd6);
    send_word(OP_READ, 4'd5, 4'd4);
    drain();

    configure(4'd0, 4'd0, 8'd255, 8'd0, 8'd1);
    run_phase(PhaseWords, 20, 67);
    drain();

    configure(4'd15, 4'd1, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
    run_phase(PhaseWords, 67, 20);
    drain();

    configure(4'($urandom_range(GRID_WIDTH - 1)), 4'd12, 8'd0, 8'd255,
              8'($urandom_range(255)));
    hold_request = 1'b1;
    run_phase(PhaseWords, 0, 0);
    drain();

    if (board.mismatches == 0 && board.pixels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
